@@ sv/cai_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cai_pkg
// Shared types and constants of the client admission table.
// ----------------------------------------------------------------------------
package cai_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;

  localparam logic [1:0] OP_CONNECT    = 2'd0;
  localparam logic [1:0] OP_DISCONNECT = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;
  localparam logic [1:0] OP_RESERVED   = 2'd3;

  localparam logic [1:0] ANS_ACK      = 2'd0;
  localparam logic [1:0] ANS_NACK     = 2'd1;
  localparam logic [1:0] ANS_DISC_ACK = 2'd2;
  localparam logic [1:0] ANS_TICK     = 2'd3;

  localparam logic [1:0] NACK_NONE     = 2'd0;
  localparam logic [1:0] NACK_NO_SPACE = 2'd1;
  localparam logic [1:0] NACK_FULL     = 2'd2;

  localparam logic [1:0] CFG_POOL_START = 2'd0;
  localparam logic [1:0] CFG_POOL_SIZE  = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT    = 2'd2;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [63:0] head;
    logic [55:0] tail;
    logic [31:0] bstart;
    logic [31:0] bsize;
    logic [31:0] seen;
  } entry_t;

endpackage

@@ sv/cai_entry_mem.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cai_entry_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cai_entry_mem #(
  parameter int DEPTH = cai_pkg::TABLE_ENTRIES_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  cai_pkg::entry_t wdata,
  input  logic [AW-1:0]   raddr,
  output cai_pkg::entry_t rdata
);

  cai_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/client_admission_ip_allocator_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// client_admission_ip_allocator_top
// Client table with lowest-fit address block allocator.
//
//  channel | ports                      | handshake
//  input   | in_* fields                | start & !busy
//  result  | out_* fields               | out_valid, one cycle
//  config  | cfg_we, cfg_index, cfg_data| cfg_we
//
// Every table read goes through one memory read port, one entry a cycle during scans.
// Tick is one table scan; disconnect is a name scan and a decision. Connect:
// name scan, decide, then N+1 gap candidates (the pool start and the end of
// each table entry, fetched first), each checked after a table scan, with no
// scan for an inactive entry. Reset clears active bits and runs a name clearing
// pass with busy high. Results cannot be stalled.
// ----------------------------------------------------------------------------
module client_admission_ip_allocator_top #(
  parameter int TABLE_ENTRIES = cai_pkg::TABLE_ENTRIES_DEF,
  parameter int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_operation,
  input  logic [63:0]        in_callsign_head,
  input  logic [55:0]        in_callsign_tail,
  input  logic [31:0]        in_requested_size,
  input  logic signed [15:0] in_timing_advance_in,
  input  logic [7:0]         in_echo_id,
  input  logic [31:0]        in_now_us,
  output logic               out_valid,
  output logic [1:0]         out_answer_kind,
  output logic [7:0]         out_client_index,
  output logic [31:0]        out_granted_start,
  output logic [31:0]        out_granted_size,
  output logic [1:0]         out_refusal_code,
  output logic               out_init_timing,
  output logic signed [15:0] out_timing_advance_out,
  output logic [6:0]         out_released_count,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_NAME, S_DECIDE, S_CAND, S_SCAN, S_EVAL,
    S_COMMIT, S_TICK, S_DONE
  } state_t;

  state_t state_r;
  logic [31:0] pool_start_r, pool_size_r, timeout_r;
  logic [TABLE_ENTRIES-1:0] act_r;
  logic [AW:0] ptr_r, cand_r;      // read pointer and candidate number
  logic        rv_r;               // read data valid for entry rv_idx_r
  logic [AW-1:0] rv_idx_r;
  logic [1:0]  op_r;
  logic [63:0] head_r;
  logic [55:0] tail_r;
  logic [31:0] req_r, now_r;
  logic signed [15:0] ta_r;
  logic [7:0]  echo_r;
  logic        hit_r;
  logic [AW-1:0] hit_idx_r, id_r;
  logic [31:0] hit_size_r, hit_start_r;
  logic        was_act_r;
  logic [32:0] pos_r, next_r;
  logic        found_r;
  logic [31:0] ans_r;
  logic [6:0]  cnt_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  cai_pkg::entry_t wdata, rdata;

  cai_entry_mem #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  // zero every character after the first zero character
  logic [63:0] nhead;
  logic [55:0] ntail;
  always_comb begin
    logic ended;
    ended = 1'b0;
    nhead = in_callsign_head;
    ntail = in_callsign_tail;
    for (int k = 0; k < 8; k++) begin
      if (ended) nhead[56-8*k +: 8] = 8'h00;
      else if (nhead[56-8*k +: 8] == 8'h00) ended = 1'b1;
    end
    for (int k = 0; k < 7; k++) begin
      if (ended) ntail[48-8*k +: 8] = 8'h00;
      else if (ntail[48-8*k +: 8] == 8'h00) ended = 1'b1;
    end
  end

  logic [32:0] pool_end;
  assign pool_end = {1'b0, pool_start_r} + {1'b0, pool_size_r};

  logic [AW-1:0] free_idx;
  logic          any_free;
  always_comb begin
    free_idx = '0;
    any_free = 1'b0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (!act_r[i]) begin
        free_idx = AW'(i);
        any_free = 1'b1;
      end
    end
  end

  logic last_ptr;
  assign last_ptr = (ptr_r == (AW+1)'(TABLE_ENTRIES));
  assign raddr = ptr_r[AW-1:0];
  assign busy  = (state_r != S_IDLE);

  logic [32:0] rd_end;
  assign rd_end = {1'b0, rdata.bstart} + {1'b0, rdata.bsize};

  always_comb begin
    we    = 1'b0;
    waddr = id_r;
    wdata.head   = head_r;
    wdata.tail   = tail_r;
    wdata.bstart = found_r ? ans_r : hit_start_r;
    wdata.bsize  = req_r;
    wdata.seen   = now_r;
    if (state_r == S_CLEAR) begin
      we    = 1'b1;
      waddr = ptr_r[AW-1:0];
      wdata = '0;
    end else if (state_r == S_COMMIT && found_r) begin
      we = 1'b1;
    end else if (state_r == S_DECIDE && op_r == cai_pkg::OP_CONNECT && hit_r
                 && req_r == hit_size_r) begin
      // reactivation: rewrite the entry with the new time only
      we = 1'b1;
      waddr = hit_idx_r;
      wdata.bstart = hit_start_r;
    end
  end

  always_ff @(posedge clk) begin
    out_valid <= 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        cai_pkg::CFG_POOL_START: pool_start_r <= cfg_data;
        cai_pkg::CFG_POOL_SIZE:  pool_size_r  <= cfg_data;
        cai_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data;
        default: ;
      endcase
    end
    rv_r     <= 1'b0;
    rv_idx_r <= ptr_r[AW-1:0];
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      pool_start_r <= '0;
      pool_size_r  <= '0;
      timeout_r    <= 32'hFFFF_FFFF;
      act_r        <= '0;
      ptr_r        <= '0;
      out_valid    <= 1'b0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          ptr_r <= ptr_r + 1'b1;
          if (ptr_r == (AW+1)'(TABLE_ENTRIES - 1)) state_r <= S_IDLE;
        end
        S_IDLE: begin
          ptr_r <= '0;
          if (start) begin
            op_r   <= in_operation;
            head_r <= nhead;
            tail_r <= ntail;
            req_r  <= in_requested_size;
            ta_r   <= in_timing_advance_in;
            echo_r <= in_echo_id;
            now_r  <= in_now_us;
            hit_r  <= 1'b0;
            cnt_r  <= '0;
            found_r <= 1'b0;
            ans_r  <= '0;
            unique case (in_operation)
              cai_pkg::OP_CONNECT, cai_pkg::OP_DISCONNECT: state_r <= S_NAME;
              cai_pkg::OP_TICK: state_r <= S_TICK;
              default: ;
            endcase
          end
        end
        S_NAME, S_TICK: begin
          if (!last_ptr) begin
            ptr_r <= ptr_r + 1'b1;
            rv_r  <= 1'b1;
          end
          if (rv_r) begin
            if (state_r == S_NAME) begin
              if (rdata.head == head_r && rdata.tail == tail_r) begin
                hit_r       <= 1'b1;
                hit_idx_r   <= rv_idx_r;
                hit_size_r  <= rdata.bsize;
                hit_start_r <= rdata.bstart;
              end
            end else if (act_r[rv_idx_r] && (now_r - rdata.seen) > timeout_r) begin
              act_r[rv_idx_r] <= 1'b0;
              cnt_r <= cnt_r + 1'b1;
            end
          end
          if (last_ptr && !rv_r) begin
            state_r <= (state_r == S_NAME) ? S_DECIDE : S_DONE;
          end
        end
        S_DECIDE: begin
          was_act_r <= hit_r ? act_r[hit_idx_r] : 1'b0;
          id_r      <= hit_r ? hit_idx_r : free_idx;
          cand_r    <= '0;
          pos_r     <= {1'b0, pool_start_r};
          if (op_r == cai_pkg::OP_DISCONNECT) begin
            if (hit_r) act_r[hit_idx_r] <= 1'b0;
            state_r <= S_DONE;
          end else if (hit_r && req_r == hit_size_r) begin
            act_r[hit_idx_r] <= 1'b1;
            state_r <= S_DONE;
          end else if (!hit_r && !any_free) begin
            state_r <= S_DONE;
          end else begin
            if (hit_r) act_r[hit_idx_r] <= 1'b0;
            state_r <= S_SCAN;
            ptr_r   <= '0;
            next_r  <= pool_end;
          end
        end
        S_CAND: begin
          // ptr_r holds entry cand_r-1; its end is the candidate if active
          if (rv_r) begin
            if (act_r[rv_idx_r]) begin
              pos_r   <= rd_end;
              next_r  <= pool_end;
              ptr_r   <= '0;
              state_r <= S_SCAN;
            end else begin
              state_r <= S_EVAL;
              pos_r   <= 33'h1_0000_0000;
            end
          end else begin
            rv_r <= 1'b1;
          end
        end
        S_SCAN: begin
          if (!last_ptr) begin
            ptr_r <= ptr_r + 1'b1;
            rv_r  <= 1'b1;
          end
          if (rv_r && act_r[rv_idx_r] && {1'b0, rdata.bstart} >= pos_r
              && {1'b0, rdata.bstart} < next_r) begin
            next_r <= {1'b0, rdata.bstart};
          end
          if (last_ptr && !rv_r) state_r <= S_EVAL;
        end
        S_EVAL: begin
          if (pos_r >= {1'b0, pool_start_r} && !pos_r[32]
              && !(found_r && pos_r[31:0] >= ans_r)
              && next_r >= pos_r && (next_r - pos_r) >= {1'b0, req_r}) begin
            found_r <= 1'b1;
            ans_r   <= pos_r[31:0];
          end
          cand_r <= cand_r + 1'b1;
          // point the read port at the entry of the next candidate
          ptr_r  <= cand_r;
          if (cand_r == (AW+1)'(TABLE_ENTRIES)) state_r <= S_COMMIT;
          else state_r <= S_CAND;
        end
        S_COMMIT: begin
          if (found_r) act_r[id_r] <= 1'b1;
          state_r <= S_DONE;
        end
        S_DONE: begin
          out_valid              <= 1'b1;
          out_client_index       <= '0;
          out_granted_start      <= '0;
          out_granted_size       <= '0;
          out_refusal_code       <= cai_pkg::NACK_NONE;
          out_init_timing        <= 1'b0;
          out_timing_advance_out <= '0;
          out_released_count     <= '0;
          if (op_r == cai_pkg::OP_TICK) begin
            out_answer_kind    <= cai_pkg::ANS_TICK;
            out_released_count <= cnt_r;
          end else if (op_r == cai_pkg::OP_DISCONNECT) begin
            out_answer_kind  <= cai_pkg::ANS_DISC_ACK;
            out_client_index <= echo_r;
          end else if (act_r[id_r] && (hit_r || any_free || found_r)
                       && (found_r || (hit_r && req_r == hit_size_r))) begin
            out_answer_kind        <= cai_pkg::ANS_ACK;
            out_client_index       <= 8'(id_r);
            out_granted_start      <= found_r ? ans_r : hit_start_r;
            out_granted_size       <= req_r;
            out_init_timing        <= !was_act_r;
            out_timing_advance_out <= was_act_r ? 16'sd0 : ta_r;
          end else begin
            out_answer_kind  <= cai_pkg::ANS_NACK;
            out_refusal_code <= (!hit_r && !found_r && !any_free)
                                ? cai_pkg::NACK_FULL : cai_pkg::NACK_NO_SPACE;
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
